[hw/rtl/upbf_pkg.sv]
// Package for the UTF-8 paragraph boundary finder: sizes, codes and byte decode.
package upbf_pkg;

  // Saturation bound for byte indices and the text length
  localparam int unsigned MAX_TEXT_BYTES = 65536;
  localparam int unsigned POS_W = $clog2(MAX_TEXT_BYTES + 1);
  // Output index fields are fixed at 17 bits
  localparam int unsigned OUT_W = 17;

  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_PS_LEAD = 8'hE2;
  localparam logic [7:0] BYTE_PS_MID  = 8'h80;
  localparam logic [7:0] BYTE_PS_LAST = 8'hA9;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [OUT_W-1:0] out_idx_t;

  // Kind of the delimiter that ended the previous character
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LF   = 2'd1,
    KIND_CR   = 2'd2,
    KIND_PS   = 2'd3
  } sep_kind_t;

  // Progress through the E2 80 A9 sequence
  typedef enum logic [1:0] {
    STEP_IDLE = 2'd0,
    STEP_LEAD = 2'd1,
    STEP_MID  = 2'd2
  } match_step_t;

  // Continuation bytes that follow a lead byte
  function automatic logic [2:0] cont_bytes(input logic [7:0] b);
    logic [2:0] n;
    if (b < 8'hC0)      n = 3'd0;
    else if (b < 8'hE0) n = 3'd1;
    else if (b < 8'hF0) n = 3'd2;
    else if (b < 8'hF8) n = 3'd3;
    else if (b < 8'hFC) n = 3'd4;
    else if (b < 8'hFE) n = 3'd5;
    else                n = 3'd0;
    return n;
  endfunction

endpackage

[hw/rtl/utf8_paragraph_boundary_finder.sv]
// Top level of the UTF-8 paragraph boundary finder.
// Throughput: one byte word per cycle; ready drops only while a result waits.
// The result is registered and shows in the cycle after the word flagged last_byte is taken.
// The scan state updates in one pass of decode logic between the input and the
// result register. Synchronous active-high rst clears the scan state and out_valid.
module utf8_paragraph_boundary_finder
  import upbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           text_byte,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     delimiter_index,
  output logic [OUT_W-1:0]     next_start,
  output logic                 delimiter_seen
);

  // Scan state
  pos_t        byte_position, byte_position_next;
  sep_kind_t   prev_kind, prev_kind_next;
  logic [2:0]  bytes_left, bytes_left_next;
  match_step_t match_step, match_step_next;
  logic        first_found, first_found_next;
  pos_t        first_pos, first_pos_next;
  logic        boundary_found, boundary_found_next;
  pos_t        boundary_pos, boundary_pos_next;
  logic        brk;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Per-byte decode and state update
  always_comb begin
    prev_kind_next      = prev_kind;
    bytes_left_next     = bytes_left;
    match_step_next     = match_step;
    first_found_next    = first_found;
    first_pos_next      = first_pos;
    boundary_found_next = boundary_found;
    boundary_pos_next   = boundary_pos;
    brk = (prev_kind == KIND_LF) || (prev_kind == KIND_PS) ||
          ((prev_kind == KIND_CR) && (text_byte != BYTE_LF));

    if (bytes_left == 3'd0) begin
      if (!boundary_found) begin
        if (brk) begin
          boundary_found_next = 1'b1;
          boundary_pos_next   = byte_position;
          match_step_next     = STEP_IDLE;
        end else if ((text_byte == BYTE_LF) || (text_byte == BYTE_CR)) begin
          if (!first_found) begin
            first_found_next = 1'b1;
            first_pos_next   = byte_position;
          end
          prev_kind_next  = (text_byte == BYTE_LF) ? KIND_LF : KIND_CR;
          match_step_next = STEP_IDLE;
        end else if (text_byte == BYTE_PS_LEAD) begin
          // candidate separator: keep its index, flag only on a full match
          if (!first_found) first_pos_next = byte_position;
          prev_kind_next  = KIND_NONE;
          match_step_next = STEP_LEAD;
        end else begin
          prev_kind_next  = KIND_NONE;
          match_step_next = STEP_IDLE;
        end
      end
      bytes_left_next = cont_bytes(text_byte);
    end else begin
      bytes_left_next = bytes_left - 3'd1;
      case (match_step)
        STEP_LEAD: match_step_next = (text_byte == BYTE_PS_MID) ? STEP_MID : STEP_IDLE;
        STEP_MID: begin
          match_step_next = STEP_IDLE;
          if (text_byte == BYTE_PS_LAST) begin
            prev_kind_next   = KIND_PS;
            first_found_next = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Saturating byte counter
    if (byte_position < POS_W'(MAX_TEXT_BYTES)) byte_position_next = byte_position + pos_t'(1);
    else                                        byte_position_next = byte_position;
  end

  // State registers: back to the start after the last byte of a text
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_position  <= '0;
      prev_kind      <= KIND_NONE;
      bytes_left     <= 3'd0;
      match_step     <= STEP_IDLE;
      first_found    <= 1'b0;
      first_pos      <= '0;
      boundary_found <= 1'b0;
      boundary_pos   <= '0;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      prev_kind      <= prev_kind_next;
      bytes_left     <= bytes_left_next;
      match_step     <= match_step_next;
      first_found    <= first_found_next;
      first_pos      <= first_pos_next;
      boundary_found <= boundary_found_next;
      boundary_pos   <= boundary_pos_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      delimiter_index <= OUT_W'(first_found_next ? first_pos_next : byte_position_next);
      next_start      <= OUT_W'(boundary_found_next ? boundary_pos_next : byte_position_next);
      delimiter_seen  <= first_found_next;
    end
  end

endmodule

[hw/rtl/upbf_checker.sv]
// Port-level checker for the paragraph boundary finder, with its bind.
module upbf_checker
  import upbf_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             last_byte,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] delimiter_index,
  input logic [OUT_W-1:0] next_start,
  input logic             delimiter_seen
);

  // A result stalled by the consumer holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(delimiter_index) &&
      $stable(next_start) && $stable(delimiter_seen))
    else $error("stalled result word changed");

  // The last byte of a text always yields a result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> out_valid)
    else $error("no result after last byte");

  // Without a delimiter both indices are the text length
  a_none_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !delimiter_seen |-> delimiter_index == next_start)
    else $error("indices differ with no delimiter");

  // The next paragraph never starts before the first delimiter
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && delimiter_seen |-> delimiter_index <= next_start)
    else $error("next start precedes delimiter");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind utf8_paragraph_boundary_finder upbf_checker u_upbf_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .last_byte       (last_byte),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .delimiter_index (delimiter_index),
  .next_start      (next_start),
  .delimiter_seen  (delimiter_seen)
);
